// ===== rtl/ghash_pkg.sv =====
// ----------------------------------------------------------------------------
// GHASH package
// Shared types and constants for the GF(2^128) hash accumulator.
// ----------------------------------------------------------------------------
package ghash_pkg;

    localparam int BLOCK_W     = 128;
    localparam int HALF_W      = 64;
    localparam int NBYTES_W    = 5;
    localparam int TOTAL_W     = 61;
    localparam int BLOCK_BYTES = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIGIT_W     = 8;
    localparam int STEP_CNT_W  = $clog2(BLOCK_W / DIGIT_W);

    localparam logic [1:0] MODE_AAD    = 2'd0;
    localparam logic [1:0] MODE_CT     = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    localparam logic [7:0] GF_REDUCE = 8'hE1;

    typedef enum logic [1:0] {
        OP_AAD    = 2'd0,
        OP_CT     = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [BLOCK_W-1:0]   data;
        logic [NBYTES_W-1:0]  nbytes;
    } entry_t;

endpackage

// ===== rtl/ghash_gf128_accumulator_unit.sv =====
// A finish word's hash reaches m_valid via the hold register, the queue, the
// multiplier and the result register. The multiplier consumes 8 bits of the
// operand per cycle, stalling a finish block while the result is unread; the
// front end and a 4-entry queue take up to five words back to back meanwhile.
// Reset (aresetn low, synchronous) clears the key, accumulator, byte totals,
// queue and result valid flag.
// ----------------------------------------------------------------------------
// GHASH GF(2^128) accumulator unit
// Top level: key registers, front end, entry queue and multiplier back end.
// ----------------------------------------------------------------------------
module ghash_gf128_accumulator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [ghash_pkg::HALF_W-1:0]        cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_mode,
    input  logic [ghash_pkg::HALF_W-1:0]        s_block_high,
    input  logic [ghash_pkg::HALF_W-1:0]        s_block_low,
    input  logic [ghash_pkg::NBYTES_W-1:0]      s_valid_bytes,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ghash_pkg::HALF_W-1:0]        m_hash_high,
    output logic [ghash_pkg::HALF_W-1:0]        m_hash_low
);

    logic [ghash_pkg::HALF_W-1:0]   key_high_reg;
    logic [ghash_pkg::HALF_W-1:0]   key_high_next;
    logic [ghash_pkg::HALF_W-1:0]   key_low_reg;
    logic [ghash_pkg::HALF_W-1:0]   key_low_next;
    logic                           fq_valid;
    logic                           fq_ready;
    ghash_pkg::entry_t              fq_entry;
    logic                           qb_valid;
    logic                           qb_pop;
    ghash_pkg::entry_t              qb_entry;

    always_comb begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                ghash_pkg::REG_KEY_HIGH: key_high_next = cfg_wdata;
                ghash_pkg::REG_KEY_LOW:  key_low_next  = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else begin
            key_high_reg <= key_high_next;
            key_low_reg  <= key_low_next;
        end
    end

    ghash_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_block_high  (s_block_high),
        .s_block_low   (s_block_low),
        .s_valid_bytes (s_valid_bytes),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_entry       (fq_entry)
    );

    ghash_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_entry  (fq_entry),
        .out_valid (qb_valid),
        .out_pop   (qb_pop),
        .out_entry (qb_entry)
    );

    ghash_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hash_key    ({key_high_reg, key_low_reg}),
        .q_valid     (qb_valid),
        .q_pop       (qb_pop),
        .q_entry     (qb_entry),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hash_high (m_hash_high),
        .m_hash_low  (m_hash_low)
    );

endmodule

// ===== rtl/ghash_front.sv =====
// ----------------------------------------------------------------------------
// GHASH front end
// Accepts input words, drops empty data words and reserved-mode ones, masks
// partial blocks and holds one classified entry for the queue.
// ----------------------------------------------------------------------------
module ghash_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_mode,
    input  logic [ghash_pkg::HALF_W-1:0]        s_block_high,
    input  logic [ghash_pkg::HALF_W-1:0]        s_block_low,
    input  logic [ghash_pkg::NBYTES_W-1:0]      s_valid_bytes,
    output logic                                q_valid,
    input  logic                                q_ready,
    output ghash_pkg::entry_t                   q_entry
);

    logic                                hold_valid_reg;
    logic                                hold_valid_next;
    ghash_pkg::entry_t                   hold_reg;
    ghash_pkg::entry_t                   hold_next;
    logic                                accept;
    logic                                push;
    logic                                keep;
    logic [ghash_pkg::NBYTES_W-1:0]      nsat;
    logic [ghash_pkg::BLOCK_W-1:0]       raw;
    logic [ghash_pkg::BLOCK_W-1:0]       masked;
    ghash_pkg::op_t                      op;

    assign s_ready = !hold_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;
    assign push    = hold_valid_reg && q_ready;
    assign q_valid = hold_valid_reg;
    assign q_entry = hold_reg;

    assign nsat = (s_valid_bytes > ghash_pkg::NBYTES_W'(ghash_pkg::BLOCK_BYTES))
                ? ghash_pkg::NBYTES_W'(ghash_pkg::BLOCK_BYTES) : s_valid_bytes;
    assign raw  = {s_block_high, s_block_low};

    always_comb begin
        for (int b = 0; b < ghash_pkg::BLOCK_BYTES; b++) begin
            masked[ghash_pkg::BLOCK_W-1-8*b -: 8] =
                (ghash_pkg::NBYTES_W'(b) < nsat) ? raw[ghash_pkg::BLOCK_W-1-8*b -: 8] : 8'd0;
        end
    end

    always_comb begin
        unique case (s_mode)
            ghash_pkg::MODE_AAD: begin
                op   = ghash_pkg::OP_AAD;
                keep = (nsat != '0);
            end
            ghash_pkg::MODE_CT: begin
                op   = ghash_pkg::OP_CT;
                keep = (nsat != '0);
            end
            ghash_pkg::MODE_FINISH: begin
                op   = ghash_pkg::OP_FINISH;
                keep = 1'b1;
            end
            default: begin
                op   = ghash_pkg::OP_AAD;
                keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        hold_next = hold_reg;
        if (accept) begin
            hold_next.op     = op;
            hold_next.data   = masked;
            hold_next.nbytes = nsat;
        end
        if (accept) begin
            hold_valid_next = keep;
        end else if (push) begin
            hold_valid_next = 1'b0;
        end else begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_reg <= hold_next;
    end

endmodule

// ===== rtl/ghash_queue.sv =====
// ----------------------------------------------------------------------------
// GHASH entry queue
// Small FIFO that decouples the front end from the multiplier back end.
// ----------------------------------------------------------------------------
module ghash_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ghash_pkg::entry_t   in_entry,
    output logic                out_valid,
    input  logic                out_pop,
    output ghash_pkg::entry_t   out_entry
);

    ghash_pkg::entry_t                  mem_reg [ghash_pkg::QUEUE_DEPTH];
    logic [ghash_pkg::QPTR_W-1:0]       wptr_reg;
    logic [ghash_pkg::QPTR_W-1:0]       wptr_next;
    logic [ghash_pkg::QPTR_W-1:0]       rptr_reg;
    logic [ghash_pkg::QPTR_W-1:0]       rptr_next;
    logic [ghash_pkg::QCNT_W-1:0]       cnt_reg;
    logic [ghash_pkg::QCNT_W-1:0]       cnt_next;
    logic                               push;
    logic                               pop;

    assign in_ready  = (cnt_reg != ghash_pkg::QCNT_W'(ghash_pkg::QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_pop;
    assign out_entry = mem_reg[rptr_reg];

    always_comb begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + ghash_pkg::QCNT_W'(push) - ghash_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
        if (push) begin
            mem_reg[wptr_reg] <= in_entry;
        end
    end

endmodule

// ===== rtl/ghash_back.sv =====
// ----------------------------------------------------------------------------
// GHASH back end
// Digit-serial GF(2^128) multiplier, accumulator, byte totals and result
// register.
// ----------------------------------------------------------------------------
module ghash_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [ghash_pkg::BLOCK_W-1:0]       hash_key,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  ghash_pkg::entry_t                   q_entry,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ghash_pkg::HALF_W-1:0]        m_hash_high,
    output logic [ghash_pkg::HALF_W-1:0]        m_hash_low
);

    localparam int BW = ghash_pkg::BLOCK_W;
    localparam int TW = ghash_pkg::TOTAL_W;
    localparam int CW = ghash_pkg::STEP_CNT_W;

    logic              busy_reg, busy_next;
    logic              fin_reg, fin_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [BW-1:0]     x_reg, x_next;
    logic [BW-1:0]     z_reg, z_next;
    logic [BW-1:0]     v_reg, v_next;
    logic [BW-1:0]     acc_reg, acc_next;
    logic [TW-1:0]     aad_reg, aad_next;
    logic [TW-1:0]     ct_reg, ct_next;
    logic              m_valid_reg, m_valid_next;
    logic [BW-1:0]     hash_reg, hash_next;
    logic [BW-1:0]     zt;
    logic [BW-1:0]     vt;
    logic              last;
    logic              out_free;
    logic              done;
    logic              advance;

    always_comb begin
        zt = z_reg;
        vt = v_reg;
        for (int j = 0; j < ghash_pkg::DIGIT_W; j++) begin
            if (x_reg[BW-1-j]) begin
                zt = zt ^ vt;
            end
            if (vt[0]) begin
                vt = {1'b0, vt[BW-1:1]} ^ {ghash_pkg::GF_REDUCE, {(BW-8){1'b0}}};
            end else begin
                vt = {1'b0, vt[BW-1:1]};
            end
        end
    end

    assign last     = (cnt_reg == '1);
    assign out_free = !m_valid_reg || m_ready;
    assign done     = busy_reg && last && (!fin_reg || out_free);
    assign advance  = busy_reg && (!last || done);
    assign q_pop    = q_valid && (!busy_reg || done);

    assign m_valid     = m_valid_reg;
    assign m_hash_high = hash_reg[BW-1 -: ghash_pkg::HALF_W];
    assign m_hash_low  = hash_reg[ghash_pkg::HALF_W-1:0];

    always_comb begin
        acc_next = acc_reg;
        if (done) begin
            acc_next = fin_reg ? '0 : zt;
        end

        x_next    = x_reg;
        z_next    = z_reg;
        v_next    = v_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fin_next  = fin_reg;
        aad_next  = aad_reg;
        ct_next   = ct_reg;

        if (advance) begin
            x_next   = {x_reg[BW-1-ghash_pkg::DIGIT_W:0], {ghash_pkg::DIGIT_W{1'b0}}};
            z_next   = zt;
            v_next   = vt;
            cnt_next = cnt_reg + 1'b1;
        end
        if (done) begin
            busy_next = 1'b0;
        end

        if (q_pop) begin
            z_next    = '0;
            v_next    = hash_key;
            cnt_next  = '0;
            busy_next = 1'b1;
            fin_next  = (q_entry.op == ghash_pkg::OP_FINISH);
            unique case (q_entry.op)
                ghash_pkg::OP_AAD: begin
                    x_next   = acc_next ^ q_entry.data;
                    aad_next = aad_reg + TW'(q_entry.nbytes);
                end
                ghash_pkg::OP_CT: begin
                    x_next  = acc_next ^ q_entry.data;
                    ct_next = ct_reg + TW'(q_entry.nbytes);
                end
                ghash_pkg::OP_FINISH: begin
                    x_next   = acc_next ^ {aad_reg, 3'b000, ct_reg, 3'b000};
                    aad_next = '0;
                    ct_next  = '0;
                end
                default: begin
                    x_next = acc_next;
                end
            endcase
        end

        hash_next    = hash_reg;
        m_valid_next = m_valid_reg;
        if (done && fin_reg) begin
            m_valid_next = 1'b1;
            hash_next    = zt;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            cnt_reg     <= '0;
            acc_reg     <= '0;
            aad_reg     <= '0;
            ct_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            fin_reg     <= fin_next;
            cnt_reg     <= cnt_next;
            acc_reg     <= acc_next;
            aad_reg     <= aad_next;
            ct_reg      <= ct_next;
            m_valid_reg <= m_valid_next;
        end
        x_reg    <= x_next;
        z_reg    <= z_next;
        v_reg    <= v_next;
        hash_reg <= hash_next;
    end

endmodule

// ===== rtl/ghash_checker.sv =====
// ----------------------------------------------------------------------------
// GHASH port checker
// Port-level properties of the accumulator unit, bound to the top level.
// ----------------------------------------------------------------------------
module ghash_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [1:0]                          s_mode,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [ghash_pkg::HALF_W-1:0]        m_hash_high,
    input  logic [ghash_pkg::HALF_W-1:0]        m_hash_low
);

    logic       fin_word;
    logic [3:0] fin_open_reg;
    logic [3:0] fin_open_next;

    assign fin_word = s_valid && s_ready && (s_mode == ghash_pkg::MODE_FINISH);

    assign fin_open_next = fin_open_reg + 4'(fin_word) - 4'(m_valid && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_open_reg <= '0;
        end else begin
            fin_open_reg <= fin_open_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_hash_high) && $stable(m_hash_low))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("ports not idle after reset");

    a_result_has_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (fin_open_reg != '0))
        else $error("hash appeared with no finish word outstanding");

endmodule

bind ghash_gf128_accumulator_unit ghash_checker u_ghash_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_mode      (s_mode),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_hash_high (m_hash_high),
    .m_hash_low  (m_hash_low)
);

// ===== verif/ghash_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// GHASH testbench package
// The reserved mode code used by the stimulus top.
// ----------------------------------------------------------------------------
package ghash_tb_pkg;

    localparam logic [1:0] MODE_RESERVED = 2'd3;

endpackage

// ===== verif/ghash_hash_checker.sv =====
// ----------------------------------------------------------------------------
// GHASH hash checker
// Watches the key writes and both channels of the accumulator, runs its own
// GF(2^128) multiply-accumulate on every accepted, non-dropped word and
// compares each emitted hash, field by field, with the oldest predicted hash.
// ----------------------------------------------------------------------------
module ghash_hash_checker
    import ghash_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [HALF_W-1:0]   cfg_wdata,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic [HALF_W-1:0]   s_block_high,
    input  logic [HALF_W-1:0]   s_block_low,
    input  logic [NBYTES_W-1:0] s_valid_bytes,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [HALF_W-1:0]   m_hash_high,
    input  logic [HALF_W-1:0]   m_hash_low,
    output int                  mismatches,
    output int                  pending_hashes
);

    logic [BLOCK_W-1:0] hash_key;
    logic [BLOCK_W-1:0] running_hash;
    logic [TOTAL_W-1:0] aad_bytes;
    logic [TOTAL_W-1:0] ct_bytes;
    logic [BLOCK_W-1:0] expected_hashes[$];
    int                 bad_fields = 0;

    function automatic logic [BLOCK_W-1:0] gf128_mul_key(input logic [BLOCK_W-1:0] x,
                                                       input logic [BLOCK_W-1:0] h);
        logic [BLOCK_W-1:0] prod;
        logic [BLOCK_W-1:0] v;
        logic               carry;
        prod = '0;
        v    = h;
        for (int i = BLOCK_W - 1; i >= 0; i--) begin
            if (x[i]) prod ^= v;
            carry = v[0];
            v     = v >> 1;
            if (carry) v[BLOCK_W-1 -: 8] ^= GF_REDUCE;
        end
        return prod;
    endfunction

    task automatic log_mismatch(input string what, input logic [HALF_W-1:0] want,
                                input logic [HALF_W-1:0] got);
        bad_fields++;
        if (bad_fields <= 10)
            $display("[%0t] %s mismatch: expected %h got %h", $realtime, what, want, got);
    endtask

    always @(posedge aclk) begin : watch
        logic [NBYTES_W-1:0] nbytes;
        logic [BLOCK_W-1:0]  block;
        logic [BLOCK_W-1:0]  want;
        if (!aresetn) begin
            hash_key     = '0;
            running_hash = '0;
            aad_bytes    = '0;
            ct_bytes     = '0;
            expected_hashes.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_KEY_HIGH) hash_key[BLOCK_W-1:HALF_W] = cfg_wdata;
                else hash_key[HALF_W-1:0] = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (expected_hashes.size() == 0) begin
                    log_mismatch("unexpected hash_high", '0, m_hash_high);
                end else begin
                    want = expected_hashes.pop_front();
                    if (want[BLOCK_W-1:HALF_W] !== m_hash_high)
                        log_mismatch("hash_high", want[BLOCK_W-1:HALF_W], m_hash_high);
                    if (want[HALF_W-1:0] !== m_hash_low)
                        log_mismatch("hash_low", want[HALF_W-1:0], m_hash_low);
                end
            end
            if (s_valid && s_ready) begin
                case (op_t'(s_mode))
                    OP_FINISH: begin
                        running_hash = gf128_mul_key(running_hash ^ {aad_bytes, 3'b000,
                                                                     ct_bytes, 3'b000},
                                                     hash_key);
                        expected_hashes.push_back(running_hash);
                        running_hash = '0;
                        aad_bytes    = '0;
                        ct_bytes     = '0;
                    end
                    OP_AAD, OP_CT: begin
                        if (s_valid_bytes != 0) begin
                            nbytes = (s_valid_bytes > BLOCK_BYTES) ? NBYTES_W'(BLOCK_BYTES)
                                                                   : s_valid_bytes;
                            block = {s_block_high, s_block_low}
                                    & ({BLOCK_W{1'b1}} << (8 * (BLOCK_BYTES - nbytes)));
                            running_hash = gf128_mul_key(running_hash ^ block, hash_key);
                            if (op_t'(s_mode) == OP_AAD) aad_bytes = aad_bytes + nbytes;
                            else ct_bytes = ct_bytes + nbytes;
                        end
                    end
                    default: ;
                endcase
            end
        end
        mismatches     <= bad_fields;
        pending_hashes <= expected_hashes.size();
    end

endmodule

// ===== verif/ghash_gf128_accumulator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// GHASH accumulator testbench
// Drives directed and random GCM messages through the accumulator under
// several hash keys, with random idling on both channels and one long result
// hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module ghash_gf128_accumulator_unit_tb;
    import ghash_pkg::*;
    import ghash_tb_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int PHASE_WORDS     = 325;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic                cfg_index;
    logic [HALF_W-1:0]   cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_mode;
    logic [HALF_W-1:0]   s_block_high;
    logic [HALF_W-1:0]   s_block_low;
    logic [NBYTES_W-1:0] s_valid_bytes;
    logic                m_valid;
    logic                m_ready;
    logic [HALF_W-1:0]   m_hash_high;
    logic [HALF_W-1:0]   m_hash_low;

    int mismatches;
    int pending_hashes;
    int words_sent   = 0;
    int quiet_cycles = 0;
    int stall_left   = 0;
    bit hold_req     = 1'b0;
    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;

    ghash_gf128_accumulator_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_block_high  (s_block_high),
        .s_block_low   (s_block_low),
        .s_valid_bytes (s_valid_bytes),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hash_high   (m_hash_high),
        .m_hash_low    (m_hash_low)
    );

    ghash_hash_checker hash_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_block_high   (s_block_high),
        .s_block_low    (s_block_low),
        .s_valid_bytes  (s_valid_bytes),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_high    (m_hash_high),
        .m_hash_low     (m_hash_low),
        .mismatches     (mismatches),
        .pending_hashes (pending_hashes)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side: random idling, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_OFF_CYCLES - 1;
                m_ready    = 1'b0;
            end else begin
                m_ready = !(recv_idle_en && $urandom_range(99) < 25);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("ghash_gf128_accumulator_unit_tb: FAIL");
                    $finish;
                end
            end
        end
    end

    function automatic logic [HALF_W-1:0] block_half();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(input logic [1:0] mode, input logic [HALF_W-1:0] high,
                             input logic [HALF_W-1:0] low, input logic [NBYTES_W-1:0] nbytes);
        while (send_idle_en && $urandom_range(99) < 25) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_mode        = mode;
        s_block_high  = high;
        s_block_low   = low;
        s_valid_bytes = nbytes;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (mode == MODE_FINISH || (mode != MODE_RESERVED && nbytes != 0)) words_sent++;
    endtask

    task automatic settle();
        s_valid = 1'b0;
        do @(negedge aclk); while (pending_hashes != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_key(input logic [HALF_W-1:0] high, input logic [HALF_W-1:0] low);
        cfg_we    = 1'b1;
        cfg_index = REG_KEY_HIGH;
        cfg_wdata = high;
        @(negedge aclk);
        cfg_index = REG_KEY_LOW;
        cfg_wdata = low;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    task automatic send_message();
        int n_aad;
        int n_ct;
        n_aad = $urandom_range(0, 3);
        n_ct  = $urandom_range(0, 4);
        for (int i = 0; i < n_aad; i++)
            send_word(MODE_AAD, block_half(), block_half(),
                      NBYTES_W'((i == n_aad - 1 && $urandom_range(1))
                                ? $urandom_range(1, 16) : 16));
        for (int i = 0; i < n_ct; i++)
            send_word(MODE_CT, block_half(), block_half(),
                      NBYTES_W'((i == n_ct - 1 && $urandom_range(1))
                                ? $urandom_range(1, 16) : 16));
        send_word(MODE_FINISH, block_half(), block_half(), NBYTES_W'($urandom_range(0, 31)));
    endtask

    task automatic run_phase(input logic [HALF_W-1:0] key_high, input logic [HALF_W-1:0] key_low,
                             input bit pressure, input bit calm);
        int  target;
        bit  pressed;
        settle();
        write_key(key_high, key_low);
        send_idle_en = !calm;
        recv_idle_en = !calm;
        pressed      = 1'b0;
        target       = words_sent + PHASE_WORDS;
        while (words_sent < target) begin
            if ($urandom_range(9) == 0)
                send_word(2'($urandom_range(0, 3)), block_half(), block_half(),
                          NBYTES_W'($urandom_range(0, 31)));
            else
                send_message();
            if (pressure && !pressed && words_sent > target - PHASE_WORDS / 2) begin
                hold_req = 1'b1;
                pressed  = 1'b1;
            end
        end
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_KEY_HIGH;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_mode        = MODE_AAD;
        s_block_high  = '0;
        s_block_low   = '0;
        s_valid_bytes = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        write_key({$urandom, $urandom}, {$urandom, $urandom});
        send_word(MODE_FINISH, '0, '0, 5'd0);
        send_word(MODE_FINISH, '1, '1, 5'd31);
        send_word(MODE_AAD, '1, '1, 5'd16);
        send_word(MODE_AAD, '1, '1, 5'd1);
        send_word(MODE_AAD, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 5'd8);
        send_word(MODE_CT, '1, '1, 5'd9);
        send_word(MODE_CT, {$urandom, $urandom}, {$urandom, $urandom}, 5'd15);
        send_word(MODE_CT, '0, '0, 5'd16);
        send_word(MODE_FINISH, {$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
        send_word(MODE_AAD, '1, '1, 5'd0);
        send_word(MODE_RESERVED, '1, '1, 5'd16);
        send_word(MODE_CT, '1, '1, 5'd31);
        send_word(MODE_AAD, {$urandom, $urandom}, {$urandom, $urandom}, 5'd17);
        send_word(MODE_CT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 5'd7);
        send_word(MODE_FINISH, '0, '0, 5'd1);
        send_word(MODE_CT, {$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
        send_word(MODE_FINISH, '1, '0, 5'd16);
        send_word(MODE_AAD, {$urandom, $urandom}, {$urandom, $urandom}, 5'd12);
        send_word(MODE_FINISH, '0, '1, 5'd8);
        send_word(MODE_RESERVED, '0, '0, 5'd0);
        send_word(MODE_FINISH, '0, '0, 5'd16);

        run_phase('1, '1, 1'b0, 1'b0);
        run_phase(64'h8000_0000_0000_0000, '0, 1'b1, 1'b0);
        run_phase('0, '0, 1'b0, 1'b0);
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b1);
        run_phase('0, 64'h1, 1'b0, 1'b0);
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b0);
        settle();

        if (mismatches == 0)
            $display("ghash_gf128_accumulator_unit_tb: PASS");
        else
            $display("ghash_gf128_accumulator_unit_tb: FAIL");
        $finish;
    end

endmodule
